// ----- hdl/rlf_pkg.sv -----
// rlf_pkg: shared widths, codes and structs of the rate limit fragmenter.
// No dependencies; compiled first.
package rlf_pkg;

    localparam int MAX_LINE_BYTES = 8192;
    localparam int LEN_W          = 13;
    localparam int CFG_W          = 16;
    localparam int COUNT_W        = 17;
    localparam int IDX_W          = 7;
    localparam int TIME_W         = 32;
    localparam int MIN_FRAG_LEN   = 128;
    localparam int DIV_W          = 17;
    localparam int QUOT_SHORT     = 7;
    localparam int DIV_CNT_W      = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        ST_FRAG  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RATE  = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_RATE_LIMIT     = 2'd0,
        REG_WINDOW_SECONDS = 2'd1,
        REG_MAX_FRAG_LEN   = 2'd2,
        REG_MAX_FRAG_ID    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CHECK,
        F_DIV,
        F_COUNT,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] rate_limit;
        logic [CFG_W-1:0] window_seconds;
        logic [CFG_W-1:0] max_fragment_length;
        logic [CFG_W-1:0] max_fragment_id;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        logic [CFG_W-1:0] frag_id;
        logic [IDX_W-1:0] total;
        logic [LEN_W-1:0] len;
        logic [CFG_W-1:0] flen;
        logic             hdr;
    } job_t;

    typedef struct packed {
        logic             start;
        logic             short_div;
        logic [DIV_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [CFG_W-1:0] rem;
    } div_rsp_t;

endpackage

// ----- hdl/rlf_if.sv -----
// rlf_msg_if / rlf_frag_if: valid/ready channels for message and fragment words.
// Depends on rlf_pkg.
interface rlf_msg_if import rlf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  line_length;
    logic              ends_with_newline;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, line_length, ends_with_newline, now_seconds, input ready);
    modport sink   (input valid, line_length, ends_with_newline, now_seconds, output ready);
endinterface

interface rlf_frag_if import rlf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [CFG_W-1:0] fragment_id;
    logic [IDX_W-1:0] fragment_index;
    logic [IDX_W-1:0] fragment_total;
    logic [LEN_W-1:0] byte_start;
    logic [LEN_W-1:0] byte_length;
    logic             has_header;
    logic             last;

    modport source (output valid, status, fragment_id, fragment_index, fragment_total,
                    byte_start, byte_length, has_header, last, input ready);
    modport sink   (input valid, status, fragment_id, fragment_index, fragment_total,
                    byte_start, byte_length, has_header, last, output ready);
endinterface

// ----- hdl/rlf_div.sv -----
// rlf_div: restoring divider, one quotient bit per cycle.
// Short mode runs 7 steps when the quotient is known to fit 7 bits. Depends on rlf_pkg.
module rlf_div import rlf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int SHORT_SHIFT = DIV_W - QUOT_SHORT;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [CFG_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [CFG_W:0]       trial;
    logic                 qbit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            dsr_next  = req.divisor;
            quot_next = '0;
            if (req.short_div)
            begin
                // top bits already below the divisor
                rem_next = CFG_W'(req.dividend >> QUOT_SHORT);
                dvd_next = req.dividend << SHORT_SHIFT;
                cnt_next = DIV_CNT_W'(QUOT_SHORT);
            end
            else
            begin
                rem_next = '0;
                dvd_next = req.dividend;
                cnt_next = DIV_CNT_W'(DIV_W);
            end
        end
        else if (busy_reg)
        begin
            if (qbit)
                rem_next = CFG_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[CFG_W-1:0];
            dvd_next  = dvd_reg << 1;
            quot_next = {quot_reg[DIV_W-2:0], qbit};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hdl/rlf_fifo.sv -----
// rlf_fifo: two-entry job queue between front and back.
// Depends on rlf_pkg.
module rlf_fifo import rlf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    output logic full,
    input  logic pop,
    output job_t dout,
    output logic not_empty
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   fill_reg, fill_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= din;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + AW'(1);
        if (push && !pop)
            fill_next = fill_reg + (AW+1)'(1);
        else if (pop && !push)
            fill_next = fill_reg - (AW+1)'(1);
    end

    assign full      = (fill_reg == (AW+1)'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign dout      = entry_reg[rd_ptr_reg];

endmodule

// ----- hdl/rlf_front.sv -----
// rlf_front: accepts messages, runs window and rate checks, fragment count and id.
// Depends on rlf_pkg, rlf_if, rlf_div (via request/response structs).
module rlf_front import rlf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    rlf_msg_if.sink       msg,
    output job_t          job,
    output logic          job_valid,
    input  logic          job_full,
    output div_req_t      div_req,
    input  div_rsp_t      div_rsp
);

    front_state_t       state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               nl_reg, nl_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TIME_W-1:0]  win_start_reg, win_start_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CFG_W-1:0]   cur_id_reg, cur_id_next;
    job_t               job_reg, job_next;

    logic [LEN_W-1:0]   len_cap;
    logic [LEN_W-1:0]   len_strip;
    logic [CFG_W-1:0]   flen_eff;
    logic [CFG_W-1:0]   id_limit;
    logic               expired;
    logic [COUNT_W-1:0] cnt_cur;
    logic               rate_on;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            win_start_reg <= '0;
            count_reg     <= '0;
            cur_id_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            win_start_reg <= win_start_next;
            count_reg     <= count_next;
            cur_id_reg    <= cur_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        nl_reg  <= nl_next;
        now_reg <= now_next;
        job_reg <= job_next;
    end

    always_comb
    begin
        if (32'(msg.line_length) > 32'(MAX_LINE_BYTES - 1))
            len_cap = LEN_W'(MAX_LINE_BYTES - 1);
        else
            len_cap = msg.line_length;
        len_strip = len_reg - LEN_W'(nl_reg);
        flen_eff  = (cfg.max_fragment_length < CFG_W'(MIN_FRAG_LEN)) ?
                    CFG_W'(MIN_FRAG_LEN) : cfg.max_fragment_length;
        id_limit  = (cfg.max_fragment_id == '0) ? CFG_W'(1) : cfg.max_fragment_id;
        expired   = ((now_reg - win_start_reg) >= TIME_W'(cfg.window_seconds));
        cnt_cur   = expired ? '0 : count_reg;
        rate_on   = (cfg.rate_limit != '0);
        count_sum = (COUNT_W+1)'(count_reg) + (COUNT_W+1)'(job_reg.total);
        count_sat = count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        nl_next        = nl_reg;
        now_next       = now_reg;
        win_start_next = win_start_reg;
        count_next     = count_reg;
        cur_id_next    = cur_id_reg;
        job_next       = job_reg;
        div_req        = '0;
        job_valid      = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (msg.valid)
                begin
                    len_next   = len_cap;
                    nl_next    = msg.ends_with_newline;
                    now_next   = msg.now_seconds;
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                job_next.status  = ST_FRAG;
                job_next.frag_id = '0;
                job_next.total   = '0;
                job_next.hdr     = 1'b0;
                job_next.len     = len_strip;
                job_next.flen    = flen_eff;
                if (len_reg == '0)
                begin
                    job_next.status = ST_EMPTY;
                    state_next      = F_PUSH;
                end
                else
                begin
                    if (expired)
                    begin
                        win_start_next = now_reg;
                        count_next     = '0;
                    end
                    if (rate_on && (cnt_cur >= COUNT_W'(cfg.rate_limit)))
                    begin
                        job_next.status = ST_RATE;
                        state_next      = F_PUSH;
                    end
                    else if (len_strip == '0)
                    begin
                        job_next.status = ST_EMPTY;
                        state_next      = F_PUSH;
                    end
                    else
                    begin
                        // ceil(len / flen)
                        div_req.start     = 1'b1;
                        div_req.short_div = 1'b1;
                        div_req.dividend  = DIV_W'(len_strip) + DIV_W'(flen_eff) - DIV_W'(1);
                        div_req.divisor   = flen_eff;
                        state_next        = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                if (div_rsp.done)
                begin
                    job_next.total = div_rsp.quot[IDX_W-1:0];
                    state_next     = F_COUNT;
                end
            end
            F_COUNT:
            begin
                count_next = count_sat;
                state_next = F_PUSH;
                if (rate_on && (count_sat > COUNT_W'(cfg.rate_limit)))
                    job_next.status = ST_OVER;
                else if (job_reg.total > IDX_W'(1))
                begin
                    job_next.hdr = 1'b1;
                    if (cur_id_reg < id_limit)
                    begin
                        cur_id_next      = cur_id_reg + CFG_W'(1);
                        job_next.frag_id = cur_id_reg + CFG_W'(1);
                    end
                    else
                    begin
                        // id at or above the limit: reduce it modulo the limit
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(cur_id_reg);
                        div_req.divisor  = id_limit;
                        state_next       = F_MOD;
                    end
                end
            end
            F_MOD:
            begin
                if (div_rsp.done)
                begin
                    cur_id_next      = div_rsp.rem + CFG_W'(1);
                    job_next.frag_id = div_rsp.rem + CFG_W'(1);
                    state_next       = F_PUSH;
                end
            end
            F_PUSH:
            begin
                job_valid = 1'b1;
                if (!job_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign msg.ready = (state_reg == F_IDLE);
    assign job       = job_reg;

endmodule

// ----- hdl/rlf_back.sv -----
// rlf_back: turns queued jobs into result words, one fragment per cycle while frag.ready allows.
// Depends on rlf_pkg and rlf_if.
module rlf_back import rlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_valid,
    output logic        job_pop,
    rlf_frag_if.source  frag
);

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] start_reg, start_next;

    status_t          status_reg, status_next;
    logic [CFG_W-1:0] id_reg, id_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [IDX_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0] bstart_reg, bstart_next;
    logic [LEN_W-1:0] blen_reg, blen_next;
    logic             hdr_reg, hdr_next;
    logic             last_reg, last_next;

    logic             load;
    logic [LEN_W-1:0] rest;
    logic [LEN_W-1:0] piece;
    logic [IDX_W-1:0] idx_inc;
    logic             is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            start_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        id_reg     <= id_next;
        index_reg  <= index_next;
        total_reg  <= total_next;
        bstart_reg <= bstart_next;
        blen_reg   <= blen_next;
        hdr_reg    <= hdr_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        load    = job_valid && (!out_valid_reg || frag.ready);
        rest    = job.len - start_reg;
        piece   = (CFG_W'(rest) < job.flen) ? rest : LEN_W'(job.flen);
        idx_inc = idx_reg + IDX_W'(1);
        is_last = (idx_inc == job.total);

        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        index_next     = index_reg;
        total_next     = total_reg;
        bstart_next    = bstart_reg;
        blen_next      = blen_reg;
        hdr_next       = hdr_reg;
        last_next      = last_reg;
        job_pop        = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            status_next    = job.status;
            total_next     = job.total;
            if (job.status == ST_FRAG)
            begin
                id_next     = job.frag_id;
                index_next  = idx_inc;
                bstart_next = start_reg;
                blen_next   = piece;
                hdr_next    = job.hdr;
                last_next   = is_last;
                if (is_last)
                begin
                    job_pop    = 1'b1;
                    idx_next   = '0;
                    start_next = '0;
                end
                else
                begin
                    idx_next   = idx_inc;
                    start_next = LEN_W'(CFG_W'(start_reg) + job.flen);
                end
            end
            else
            begin
                id_next     = '0;
                index_next  = '0;
                bstart_next = '0;
                blen_next   = '0;
                hdr_next    = 1'b0;
                last_next   = 1'b1;
                job_pop     = 1'b1;
            end
        end
        else if (frag.ready)
            out_valid_next = 1'b0;
    end

    assign frag.valid          = out_valid_reg;
    assign frag.status         = status_reg;
    assign frag.fragment_id    = id_reg;
    assign frag.fragment_index = index_reg;
    assign frag.fragment_total = total_reg;
    assign frag.byte_start     = bstart_reg;
    assign frag.byte_length    = blen_reg;
    assign frag.has_header     = hdr_reg;
    assign frag.last           = last_reg;

endmodule

// ----- hdl/windowed_rate_limit_fragmenter.sv -----
// Windowed rate limiter and message fragmenter, top level with APB registers.
// A message passes F_CHECK, F_DIV, F_COUNT, F_PUSH, the queue and the back; empty or
// rate-dropped ones skip F_DIV and F_COUNT, and F_MOD sends the id through the
// divider when it reaches max_fragment_id. The front takes one message at a time
// (7-step divider for the count); the back emits one fragment per cycle when ready.
// Reset (rst_n, async, low): config to defaults, window, count and id cleared.
module windowed_rate_limit_fragmenter import rlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rlf_msg_if.sink     msg,
    rlf_frag_if.source  frag
);

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [1:0] reg_sel;

    job_t       front_job;
    logic       front_valid;
    logic       fifo_full;
    logic       fifo_push;
    job_t       back_job;
    logic       back_valid;
    logic       back_pop;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_limit          <= CFG_W'(0);
            cfg_reg.window_seconds      <= CFG_W'(1);
            cfg_reg.max_fragment_length <= CFG_W'(245);
            cfg_reg.max_fragment_id     <= CFG_W'(99);
        end
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                REG_RATE_LIMIT:     cfg_next.rate_limit          = pwdata[CFG_W-1:0];
                REG_WINDOW_SECONDS: cfg_next.window_seconds      = pwdata[CFG_W-1:0];
                REG_MAX_FRAG_LEN:   cfg_next.max_fragment_length = pwdata[CFG_W-1:0];
                REG_MAX_FRAG_ID:    cfg_next.max_fragment_id     = pwdata[CFG_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_RATE_LIMIT:     prdata = 32'(cfg_reg.rate_limit);
            REG_WINDOW_SECONDS: prdata = 32'(cfg_reg.window_seconds);
            REG_MAX_FRAG_LEN:   prdata = 32'(cfg_reg.max_fragment_length);
            REG_MAX_FRAG_ID:    prdata = 32'(cfg_reg.max_fragment_id);
            default:            prdata = '0;
        endcase
    end

    assign fifo_push = front_valid && !fifo_full;

    rlf_div u_div
    (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    rlf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .msg       (msg),
        .job       (front_job),
        .job_valid (front_valid),
        .job_full  (fifo_full),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    rlf_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .din       (front_job),
        .full      (fifo_full),
        .pop       (back_pop),
        .dout      (back_job),
        .not_empty (back_valid)
    );

    rlf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_pop   (back_pop),
        .frag      (frag)
    );

endmodule

// ----- hdl/rlf_checker.sv -----
// rlf_checker: port-level assertions on the fragment word stream, bound to the top.
// Depends on rlf_pkg and windowed_rate_limit_fragmenter.
module rlf_checker import rlf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             frag_valid,
    input logic             frag_ready,
    input logic [1:0]       status,
    input logic [CFG_W-1:0] fragment_id,
    input logic [IDX_W-1:0] fragment_index,
    input logic [IDX_W-1:0] fragment_total,
    input logic [LEN_W-1:0] byte_start,
    input logic [LEN_W-1:0] byte_length,
    input logic             has_header,
    input logic             last
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag_ready |=> frag_valid)
        else $error("fragment word dropped while stalled");

    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && !frag_ready |=> $stable({status, fragment_id, fragment_index,
            fragment_total, byte_start, byte_length, has_header, last}))
        else $error("fragment word changed while stalled");

    a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && (status != ST_FRAG) |->
            last && (fragment_index == '0) && (byte_length == '0) && !has_header)
        else $error("bad non-fragment word");

    a_frag_seq: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && (status == ST_FRAG) |->
            (fragment_index != '0) && (fragment_index <= fragment_total) &&
            (last == (fragment_index == fragment_total)) &&
            (has_header == (fragment_total > IDX_W'(1))))
        else $error("inconsistent fragment position");

    a_full_frag: assert property (@(posedge clk) disable iff (!rst_n)
        frag_valid && (status == ST_FRAG) && !last |->
            (32'(byte_length) >= 32'(MIN_FRAG_LEN)))
        else $error("short fragment before last");

endmodule

bind windowed_rate_limit_fragmenter rlf_checker u_rlf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .frag_valid     (frag.valid),
    .frag_ready     (frag.ready),
    .status         (frag.status),
    .fragment_id    (frag.fragment_id),
    .fragment_index (frag.fragment_index),
    .fragment_total (frag.fragment_total),
    .byte_start     (frag.byte_start),
    .byte_length    (frag.byte_length),
    .has_header     (frag.has_header),
    .last           (frag.last)
);

// ----- tb/sv/windowed_rate_limit_fragmenter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for windowed_rate_limit_fragmenter: directed table, a
// back-to-back burst and randomized phases, checked against an in-bench fragment predictor.
// Depends on rlf_pkg, rlf_if (rlf_msg_if, rlf_frag_if) and the top level RTL.
module windowed_rate_limit_fragmenter_tb import rlf_pkg::*;
;

    localparam int unsigned COUNT_MAX        = (1 << COUNT_W) - 1;
    localparam int          STALL_LIMIT      = 4000;
    localparam int          SINK_HOLD_CYCLES = 600;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          PHASE_ITEMS      = 20;
    localparam int          BURST_ITEMS      = 10;
    localparam int          IDLE_PCT         = 37;

    typedef enum logic {
        ROW_MSG,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        status_t          status;
        logic [CFG_W-1:0] frag_id;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] total;
        logic [LEN_W-1:0] byte_start;
        logic [LEN_W-1:0] byte_len;
        logic             hdr;
        logic             last;
    } frag_word_t;

    typedef struct {
        row_kind_t         kind;
        cfg_reg_t          reg_sel;
        logic [CFG_W-1:0]  reg_val;
        logic [LEN_W-1:0]  len;
        logic              nl;
        logic [TIME_W-1:0] now;
        logic              typed;
        status_t           typed_status;
        logic [IDX_W-1:0]  typed_total;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rlf_msg_if  msg_ch ();
    rlf_frag_if frag_ch ();

    windowed_rate_limit_fragmenter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .msg     (msg_ch),
        .frag    (frag_ch)
    );

    // predictor state and register copy
    logic [CFG_W-1:0]  cfg_rate;
    logic [CFG_W-1:0]  cfg_window;
    logic [CFG_W-1:0]  cfg_flen;
    logic [CFG_W-1:0]  cfg_id_max;
    logic [TIME_W-1:0] win_start;
    int unsigned       msg_count;
    logic [CFG_W-1:0]  cur_frag_id;

    frag_word_t pending_frags[$];
    frag_word_t got_word;
    frag_word_t want_word;
    int         mismatch_count;
    int         quiet_cycles;
    bit         idle_en;
    bit         sink_stall_req;
    int         sink_stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic frag_word_t drop_word(input status_t st, input logic [IDX_W-1:0] total);
        return '{status: st, frag_id: '0, index: '0, total: total, byte_start: '0,
                 byte_len: '0, hdr: 1'b0, last: 1'b1};
    endfunction

    function automatic string fmt_word(input frag_word_t w);
        return $sformatf("st=%0d id=%0d idx=%0d tot=%0d start=%0d len=%0d hdr=%0b last=%0b",
                         w.status, w.frag_id, w.index, w.total, w.byte_start, w.byte_len,
                         w.hdr, w.last);
    endfunction

    function automatic void predict_message(input logic [LEN_W-1:0] line_len, input logic nl,
                                            input logic [TIME_W-1:0] now,
                                            ref frag_word_t words[$]);
        int unsigned      len;
        int unsigned      flen;
        int unsigned      n;
        int unsigned      id_limit;
        int unsigned      start;
        int unsigned      piece;
        logic [CFG_W-1:0] id;
        logic             hdr;
        len = 32'(line_len);
        if (len == 0)
        begin
            words.push_back(drop_word(ST_EMPTY, '0));
            return;
        end
        if (TIME_W'(now - win_start) >= TIME_W'(cfg_window))
        begin
            msg_count = 0;
            win_start = now;
        end
        if (cfg_rate != '0 && msg_count >= 32'(cfg_rate))
        begin
            words.push_back(drop_word(ST_RATE, '0));
            return;
        end
        if (nl)
            len = len - 1;
        if (len == 0)
        begin
            words.push_back(drop_word(ST_EMPTY, '0));
            return;
        end
        flen = (32'(cfg_flen) < 32'(MIN_FRAG_LEN)) ? 32'(MIN_FRAG_LEN) : 32'(cfg_flen);
        n = (len + flen - 1) / flen;
        msg_count = msg_count + n;
        if (msg_count > COUNT_MAX)
            msg_count = COUNT_MAX;
        if (cfg_rate != '0 && msg_count > 32'(cfg_rate))
        begin
            words.push_back(drop_word(ST_OVER, IDX_W'(n)));
            return;
        end
        id = '0;
        hdr = 1'b0;
        if (n > 1)
        begin
            id_limit = (cfg_id_max == '0) ? 1 : 32'(cfg_id_max);
            cur_frag_id = CFG_W'((32'(cur_frag_id) % id_limit) + 1);
            id = cur_frag_id;
            hdr = 1'b1;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            start = i * flen;
            piece = (len - start < flen) ? len - start : flen;
            words.push_back('{status: ST_FRAG, frag_id: id, index: IDX_W'(i + 1),
                              total: IDX_W'(n), byte_start: LEN_W'(start),
                              byte_len: LEN_W'(piece), hdr: hdr, last: (i + 1 == n)});
        end
    endfunction

    function automatic dir_row_t msg_row(input logic [LEN_W-1:0] len, input logic nl,
                                         input logic [TIME_W-1:0] now,
                                         input logic typed = 1'b0,
                                         input status_t st = ST_FRAG,
                                         input logic [IDX_W-1:0] total = '0);
        return '{kind: ROW_MSG, reg_sel: REG_RATE_LIMIT, reg_val: '0, len: len, nl: nl,
                 now: now, typed: typed, typed_status: st, typed_total: total};
    endfunction

    function automatic dir_row_t cfg_row(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        return '{kind: ROW_CFG, reg_sel: r, reg_val: v, len: '0, nl: 1'b0, now: '0,
                 typed: 1'b0, typed_status: ST_FRAG, typed_total: '0};
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] value);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= {16'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        case (r)
            REG_RATE_LIMIT:     cfg_rate = value;
            REG_WINDOW_SECONDS: cfg_window = value;
            REG_MAX_FRAG_LEN:   cfg_flen = value;
            REG_MAX_FRAG_ID:    cfg_id_max = value;
            default:            ;
        endcase
        if (readback !== {16'b0, value})
            note_mismatch($sformatf("reg %s read %h, want %h", r.name(), readback, value));
    endtask

    task automatic send_msg(input logic [LEN_W-1:0] len, input logic nl,
                            input logic [TIME_W-1:0] now, input logic typed,
                            input status_t st, input logic [IDX_W-1:0] total);
        frag_word_t predicted[$];
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.line_length <= len;
        msg_ch.ends_with_newline <= nl;
        msg_ch.now_seconds <= now;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        predict_message(len, nl, now, predicted);
        if (typed)
            pending_frags.push_back(drop_word(st, total));
        else
            foreach (predicted[i])
                pending_frags.push_back(predicted[i]);
    endtask

    task automatic drain;
        msg_ch.valid <= 1'b0;
        while (pending_frags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] window,
                             input logic [CFG_W-1:0] flen, input logic [CFG_W-1:0] id_max,
                             input bit hold, input logic [TIME_W-1:0] base_now);
        logic [TIME_W-1:0] now;
        logic [LEN_W-1:0]  len;
        int                pick;
        drain();
        write_reg(REG_RATE_LIMIT, rate);
        write_reg(REG_WINDOW_SECONDS, window);
        write_reg(REG_MAX_FRAG_LEN, flen);
        write_reg(REG_MAX_FRAG_ID, id_max);
        idle_en = 1'b1;
        if (hold)
            sink_stall_req = 1'b1;
        now = base_now;
        repeat (PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                len = '0;
            else if (pick < 16)
                len = LEN_W'(1);
            else if (pick < 24)
                len = LEN_W'($urandom_range(4096, 8191));
            else if (pick < 27)
                len = '1;
            else
                len = LEN_W'($urandom_range(2, 600));
            pick = $urandom_range(99);
            if (pick < 65)
                now = now + $urandom_range(0, 1);
            else if (pick < 92)
                now = now + $urandom_range(2, 12);
            else
                now = now + $urandom;
            send_msg(len, 1'($urandom_range(1)), now, 1'b0, ST_FRAG, '0);
        end
    endtask

    // sink side: random ready, plus one long hold-off on request
    initial
    begin
        frag_ch.ready = 1'b0;
        sink_stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_stall_req)
            begin
                sink_stall_req = 1'b0;
                sink_stall_left = SINK_HOLD_CYCLES;
            end
            if (sink_stall_left > 0)
            begin
                sink_stall_left--;
                frag_ch.ready <= 1'b0;
            end
            else
                frag_ch.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frag_ch.valid && frag_ch.ready)
        begin
            got_word = '{status: status_t'(frag_ch.status), frag_id: frag_ch.fragment_id,
                         index: frag_ch.fragment_index, total: frag_ch.fragment_total,
                         byte_start: frag_ch.byte_start, byte_len: frag_ch.byte_length,
                         hdr: frag_ch.has_header, last: frag_ch.last};
            if (pending_frags.size() == 0)
                note_mismatch({"unexpected word ", fmt_word(got_word)});
            else
            begin
                want_word = pending_frags.pop_front();
                if (got_word.status !== want_word.status ||
                    got_word.frag_id !== want_word.frag_id ||
                    got_word.index !== want_word.index ||
                    got_word.total !== want_word.total ||
                    got_word.byte_start !== want_word.byte_start ||
                    got_word.byte_len !== want_word.byte_len ||
                    got_word.hdr !== want_word.hdr ||
                    got_word.last !== want_word.last)
                    note_mismatch({"got ", fmt_word(got_word), " want ", fmt_word(want_word)});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (msg_ch.valid && msg_ch.ready) || (frag_ch.valid && frag_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("[windowed_rate_limit_fragmenter] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        dir_row_t rows[$];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        msg_ch.valid = 1'b0;
        msg_ch.line_length = '0;
        msg_ch.ends_with_newline = 1'b0;
        msg_ch.now_seconds = '0;
        cfg_rate = '0;
        cfg_window = 1;
        cfg_flen = 245;
        cfg_id_max = 99;
        win_start = '0;
        msg_count = 0;
        cur_frag_id = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        idle_en = 1'b1;
        sink_stall_req = 1'b0;

        // defaults: unlimited rate, 1 s window, 245 byte fragments, ids up to 99
        rows.push_back(msg_row(0, 1'b0, 0, 1'b1, ST_EMPTY, 0));
        rows.push_back(msg_row(1, 1'b1, 0, 1'b1, ST_EMPTY, 0));
        rows.push_back(msg_row(1, 1'b0, 0));
        rows.push_back(msg_row(245, 1'b0, 0));
        rows.push_back(msg_row(246, 1'b1, 0));
        rows.push_back(msg_row(246, 1'b0, 5));
        rows.push_back(msg_row(8191, 1'b0, 5));
        rows.push_back(msg_row(8191, 1'b1, 32'hFFFF_FFFF));
        rows.push_back(msg_row(300, 1'b0, 3));
        rows.push_back(cfg_row(REG_MAX_FRAG_LEN, 0));
        rows.push_back(msg_row(8191, 1'b0, 10));
        rows.push_back(msg_row(129, 1'b1, 10));
        rows.push_back(cfg_row(REG_MAX_FRAG_LEN, 16'hFFFF));
        rows.push_back(cfg_row(REG_MAX_FRAG_ID, 0));
        rows.push_back(msg_row(8191, 1'b0, 11));
        rows.push_back(cfg_row(REG_MAX_FRAG_LEN, 127));
        rows.push_back(msg_row(257, 1'b0, 11));
        rows.push_back(msg_row(300, 1'b0, 11));
        rows.push_back(cfg_row(REG_MAX_FRAG_ID, 2));
        rows.push_back(msg_row(400, 1'b0, 12));
        rows.push_back(msg_row(400, 1'b0, 12));
        rows.push_back(msg_row(400, 1'b1, 12));
        rows.push_back(cfg_row(REG_RATE_LIMIT, 3));
        rows.push_back(cfg_row(REG_WINDOW_SECONDS, 100));
        rows.push_back(msg_row(300, 1'b0, 1000));
        rows.push_back(msg_row(10, 1'b0, 1000, 1'b1, ST_RATE, 0));
        rows.push_back(msg_row(0, 1'b0, 1000, 1'b1, ST_EMPTY, 0));
        rows.push_back(msg_row(1, 1'b0, 1100));
        rows.push_back(msg_row(8191, 1'b0, 1100, 1'b1, ST_OVER, 64));
        rows.push_back(msg_row(5, 1'b0, 1100, 1'b1, ST_RATE, 0));
        rows.push_back(cfg_row(REG_WINDOW_SECONDS, 0));
        rows.push_back(msg_row(5, 1'b0, 1100));
        rows.push_back(msg_row(5, 1'b1, 1100));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(rows[i].reg_sel, rows[i].reg_val);
            end
            else
                send_msg(rows[i].len, rows[i].nl, rows[i].now, rows[i].typed,
                         rows[i].typed_status, rows[i].typed_total);
        end

        // no idling on either side: maximum-length messages back to back
        drain();
        write_reg(REG_RATE_LIMIT, 0);
        write_reg(REG_WINDOW_SECONDS, 16'hFFFF);
        write_reg(REG_MAX_FRAG_LEN, CFG_W'(MIN_FRAG_LEN));
        write_reg(REG_MAX_FRAG_ID, 16'hFFFF);
        idle_en = 1'b0;
        repeat (BURST_ITEMS)
            send_msg('1, 1'b0, 32'h0001_0000, 1'b0, ST_FRAG, '0);
        drain();

        run_phase(0, 1, CFG_W'(MIN_FRAG_LEN), 1, 1'b0, $urandom);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, $urandom);
        run_phase(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 5)),
                  CFG_W'($urandom_range(128, 1000)), CFG_W'($urandom_range(1, 5)), 1'b0,
                  32'hFFFF_FFF0);
        run_phase(1, 2, CFG_W'($urandom_range(0, 127)), 0, 1'b0, $urandom);
        run_phase(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(1, 10)),
                  CFG_W'($urandom_range(128, 2000)), CFG_W'($urandom_range(1, 10)), 1'b1,
                  $urandom);
        run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                  1'b0, $urandom);
        drain();

        if (mismatch_count == 0)
            $display("[windowed_rate_limit_fragmenter] OK");
        else
            $display("[windowed_rate_limit_fragmenter] ERROR");
        $finish;
    end

endmodule
